[design/gws_pkg.sv]
// Shared types, constants and helper functions for the Gerstner wave sum block.
// The per-wave coefficient table is built here at elaboration from the wave set.
// Used by gws_sincos, gws_norm and gerstner_wave_sum.
package gws_pkg;

   localparam int unsigned NumWaves = 8;
   localparam int unsigned WaveBits = (NumWaves > 1) ? $clog2(NumWaves) : 1;
   localparam int unsigned AccBits = 36;
   localparam int unsigned SinLat = 7;
   localparam int unsigned SqrtSteps = 32;
   localparam int unsigned DivBits = 15;

   localparam logic [30:0] OneQ30 = 31'd1073741824;
   localparam logic [30:0] SinC1 = 31'd1686629713;
   localparam logic [30:0] SinC3 = 31'd693598668;
   localparam logic [30:0] SinC5 = 31'd85569306;
   localparam logic [30:0] SinC7 = 31'd5026995;
   localparam logic [30:0] SinC9 = 31'd172272;

   localparam longint unsigned InvL0 = 64'd536870912;
   localparam longint unsigned Amp0 = 64'd644245094;
   localparam longint unsigned GOver2Pi = 64'd6705775346;
   localparam longint unsigned TwoPiQ16 = 64'd411775;
   localparam longint unsigned SteepNum = 64'd84442493013197;
   localparam longint unsigned AngleStep = 64'd205069582;
   localparam longint unsigned QOne = 64'd65536;

   localparam logic [14:0] NormOne = 15'd16384;

   typedef struct packed {
      logic signed [31:0] fx;
      logic signed [31:0] fz;
      logic [31:0]        ft;
      logic signed [31:0] amp;
      logic signed [31:0] cx;
      logic signed [31:0] cz;
      logic signed [31:0] kx;
      logic signed [31:0] kz;
      logic signed [31:0] qka;
   } coeff_type;

   typedef coeff_type [NumWaves-1:0] coeff_tab_type;

   typedef struct packed {
      logic signed [31:0] disp_x;
      logic signed [31:0] disp_y;
      logic signed [31:0] disp_z;
      logic signed [31:0] height;
   } pay_type;

   typedef struct packed {
      logic                      valid;
      logic signed [31:0]        px;
      logic signed [31:0]        pz;
      logic signed [AccBits-1:0] sx;
      logic signed [AccBits-1:0] sy;
      logic signed [AccBits-1:0] sz;
      logic signed [AccBits-1:0] nx;
      logic signed [AccBits-1:0] ny;
      logic signed [AccBits-1:0] nz;
   } sum_type;

   typedef struct packed {
      logic               valid;
      pay_type            pay;
      logic signed [15:0] norm_x;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_z;
   } res_type;

   function automatic longint sin_c(longint u);
      longint q;
      longint r;
      longint x2;
      longint p;
      longint s;
      q = (u >> 30) & 3;
      r = u & 64'h3FFF_FFFF;
      if ((q & 1) != 0) r = longint'(OneQ30) - r;
      x2 = (r * r) >> 30;
      p = longint'(SinC9);
      p = longint'(SinC7) - ((x2 * p) >> 30);
      p = longint'(SinC5) - ((x2 * p) >> 30);
      p = longint'(SinC3) - ((x2 * p) >> 30);
      p = longint'(SinC1) - ((x2 * p) >> 30);
      s = (r * p) >> 30;
      if (s > longint'(OneQ30)) s = longint'(OneQ30);
      return ((q & 2) != 0) ? -s : s;
   endfunction

   function automatic longint mulsh_c(longint a, longint b);
      logic   neg;
      longint ua;
      longint ub;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? -a : a;
      ub = (b < 0) ? -b : b;
      return neg ? -((ua * ub) >> 30) : ((ua * ub) >> 30);
   endfunction

   function automatic longint unsigned isqrt_c(longint unsigned n);
      longint unsigned rem;
      longint unsigned r;
      longint unsigned b;
      rem = n;
      r = 0;
      b = 64'd1 << 62;
      for (int k = 0; k < 32; k++) begin
         if (rem >= r + b) begin
            rem = rem - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned udiv_c(longint unsigned n, longint unsigned d);
      longint unsigned rem;
      longint unsigned q;
      rem = 0;
      q = 0;
      for (int k = 63; k >= 0; k--) begin
         rem = (rem << 1) | ((n >> k) & 64'd1);
         if (rem >= d) begin
            rem = rem - d;
            q = q | (64'd1 << k);
         end
      end
      return q;
   endfunction

   function automatic coeff_tab_type build_coeffs();
      coeff_tab_type   tab;
      longint unsigned v;
      longint unsigned a;
      longint unsigned den;
      longint unsigned q;
      longint unsigned ka;
      longint unsigned angw;
      logic [31:0]     ang;
      longint          dx;
      longint          dy;
      longint          qa;
      longint          qka;
      v = InvL0;
      a = Amp0;
      for (int i = 0; i < NumWaves; i++) begin
         if (i > 0) begin
            v = v * 5 / 9;
            a = a * 3 / 5;
         end
         den = longint'(NumWaves) * a;
         q = (den != 0) ? udiv_c(SteepNum, den) : QOne;
         if (q > QOne) q = QOne;
         ka = (((a * v) >> 16) * TwoPiQ16) >> 32;
         angw = AngleStep * longint'(i) / NumWaves;
         ang = angw[31:0];
         if ((i & 1) != 0) ang = 32'd0 - ang;
         dx = sin_c(longint'({32'd0, ang + 32'h4000_0000}));
         dy = sin_c(longint'({32'd0, ang}));
         qa = longint'((a * q) >> 16);
         qka = longint'((ka * q) >> 16);
         tab[i].fx = 32'(mulsh_c(dx, longint'(v)));
         tab[i].fz = 32'(mulsh_c(dy, longint'(v)));
         tab[i].ft = 32'(isqrt_c(GOver2Pi * v));
         tab[i].amp = 32'(a);
         tab[i].cx = 32'(mulsh_c(qa, dx));
         tab[i].cz = 32'(mulsh_c(qa, dy));
         tab[i].kx = 32'(mulsh_c(longint'(ka), dx));
         tab[i].kz = 32'(mulsh_c(longint'(ka), dy));
         tab[i].qka = 32'(qka);
      end
      return tab;
   endfunction

   function automatic logic signed [31:0] mul_q30(logic signed [31:0] k, logic signed [31:0] x);
      logic        neg;
      logic [31:0] mk;
      logic [31:0] mx;
      logic [63:0] prod;
      neg = k[31] ^ x[31];
      mk = k[31] ? 32'(~k + 32'd1) : k;
      mx = x[31] ? 32'(~x + 32'd1) : x;
      prod = 64'(mk) * 64'(mx);
      return neg ? 32'(~prod[61:30] + 32'd1) : prod[61:30];
   endfunction

   function automatic logic signed [31:0] sat32(logic signed [39:0] v);
      if (v > 40'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -40'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

endpackage

[design/gws_sincos.sv]
// Pipelined sine of a 32-bit turn phase, Q30 result, seven register stages.
// Quarter-wave odd polynomial evaluated by Horner steps; constants from gws_pkg.
module gws_sincos (
   input  logic               clock,
   input  logic               adv,
   input  logic [31:0]        phase,
   output logic signed [31:0] sine
);

   logic [30:0]        r_ff [6];
   logic               neg_ff [6];
   logic [30:0]        x2_ff [4];
   logic [30:0]        p_ff [4];
   logic signed [31:0] s_ff;
   logic [30:0]        r_in;
   logic [61:0]        rr;
   logic [30:0]        x2_in;
   logic [30:0]        p_in [4];
   logic [61:0]        sp;
   logic [31:0]        smag;
   logic signed [31:0] s_in;

   function automatic logic [30:0] horner(logic [30:0] x2, logic [30:0] p, logic [30:0] c);
      logic [61:0] prod;
      prod = 62'(x2) * 62'(p);
      return c - prod[60:30];
   endfunction

   function automatic logic [30:0] OneQ30Sub(logic [29:0] f);
      return gws_pkg::OneQ30 - {1'b0, f};
   endfunction

   always_comb begin
      r_in = phase[30] ? OneQ30Sub(phase[29:0]) : {1'b0, phase[29:0]};
      rr = 62'(r_ff[0]) * 62'(r_ff[0]);
      x2_in = rr[60:30];
      p_in[0] = horner(x2_ff[0], gws_pkg::SinC9, gws_pkg::SinC7);
      p_in[1] = horner(x2_ff[1], p_ff[0], gws_pkg::SinC5);
      p_in[2] = horner(x2_ff[2], p_ff[1], gws_pkg::SinC3);
      p_in[3] = horner(x2_ff[3], p_ff[2], gws_pkg::SinC1);
      sp = 62'(r_ff[5]) * 62'(p_ff[3]);
      smag = sp[61:30];
      if (smag > 32'(gws_pkg::OneQ30)) smag = 32'(gws_pkg::OneQ30);
      s_in = neg_ff[5] ? 32'(~smag + 32'd1) : smag;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff[0] <= r_in;
         neg_ff[0] <= phase[31];
         for (int k = 1; k < 6; k++) begin
            r_ff[k] <= r_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
         end
         x2_ff[0] <= x2_in;
         for (int k = 1; k < 4; k++) begin
            x2_ff[k] <= x2_ff[k-1];
         end
         for (int k = 0; k < 4; k++) begin
            p_ff[k] <= p_in[k];
         end
         s_ff <= s_in;
      end
   end

   assign sine = s_ff;

endmodule

[design/gws_norm.sv]
// Output stage of the wave sum: saturating displacement outputs and normal scaling.
// Pipelined integer square root and restoring divisions; types from gws_pkg.
module gws_norm (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic signed [31:0]  sea_level,
   input  gws_pkg::sum_type    sum,
   output gws_pkg::res_type    res
);

   typedef struct packed {
      logic               valid;
      gws_pkg::pay_type   pay;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] vz;
   } vec_type;

   typedef struct packed {
      logic               valid;
      gws_pkg::pay_type   pay;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] vz;
      logic [63:0]        qx;
      logic [63:0]        qy;
      logic [63:0]        qz;
   } sq_type;

   typedef struct packed {
      logic               valid;
      gws_pkg::pay_type   pay;
      logic               zero;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] vz;
      logic [63:0]        n;
      logic [63:0]        r;
   } root_type;

   typedef struct packed {
      logic             valid;
      gws_pkg::pay_type pay;
      logic             zero;
      logic [2:0]       neg;
      logic [31:0]      len;
      logic [2:0][47:0] rem;
      logic [2:0][14:0] q;
   } div_type;

   vec_type          vec_ff;
   vec_type          vec_in;
   sq_type           sq_ff;
   sq_type           sq_in;
   root_type         root_src [gws_pkg::SqrtSteps];
   root_type         root_in [gws_pkg::SqrtSteps];
   root_type         root_ff [gws_pkg::SqrtSteps];
   div_type          div_src [gws_pkg::DivBits + 1];
   div_type          div_in [gws_pkg::DivBits + 1];
   div_type          div_ff [gws_pkg::DivBits + 1];
   gws_pkg::res_type res_ff;
   gws_pkg::res_type res_in;

   function automatic root_type root_step(root_type st, int k);
      root_type    o;
      logic [63:0] b;
      logic [63:0] rb;
      o = st;
      b = 64'd1 << (62 - 2 * k);
      rb = st.r + b;
      if (st.n >= rb) begin
         o.n = st.n - rb;
         o.r = (st.r >> 1) + b;
      end else begin
         o.r = st.r >> 1;
      end
      return o;
   endfunction

   function automatic logic [31:0] mag32(logic signed [31:0] v);
      return v[31] ? 32'(~v + 32'd1) : v;
   endfunction

   function automatic logic signed [15:0] finish(logic [14:0] q, logic neg);
      logic [14:0] c;
      c = (q > gws_pkg::NormOne) ? gws_pkg::NormOne : q;
      return neg ? 16'(~{1'b0, c} + 16'd1) : {1'b0, c};
   endfunction

   always_comb begin
      logic signed [19:0] sx16;
      logic signed [19:0] sy16;
      logic signed [19:0] sz16;
      logic [63:0]        m2;
      sx16 = $signed(sum.sx[35:16]);
      sy16 = $signed(sum.sy[35:16]);
      sz16 = $signed(sum.sz[35:16]);
      vec_in.valid = sum.valid;
      vec_in.pay.disp_x = gws_pkg::sat32($signed({{8{sum.px[31]}}, sum.px})
                                         + $signed({{20{sx16[19]}}, sx16}));
      vec_in.pay.disp_y = gws_pkg::sat32($signed({{20{sy16[19]}}, sy16}));
      vec_in.pay.disp_z = gws_pkg::sat32($signed({{8{sum.pz[31]}}, sum.pz})
                                         + $signed({{20{sz16[19]}}, sz16}));
      vec_in.pay.height = gws_pkg::sat32($signed({{8{sea_level[31]}}, sea_level})
                                         + $signed({{20{sy16[19]}}, sy16}));
      vec_in.vx = $signed(sum.nx[35:4]);
      vec_in.vy = $signed(sum.ny[35:4]);
      vec_in.vz = $signed(sum.nz[35:4]);

      sq_in.valid = vec_ff.valid;
      sq_in.pay = vec_ff.pay;
      sq_in.vx = vec_ff.vx;
      sq_in.vy = vec_ff.vy;
      sq_in.vz = vec_ff.vz;
      sq_in.qx = 64'(vec_ff.vx * vec_ff.vx);
      sq_in.qy = 64'(vec_ff.vy * vec_ff.vy);
      sq_in.qz = 64'(vec_ff.vz * vec_ff.vz);

      m2 = sq_ff.qx + sq_ff.qy + sq_ff.qz;
      root_src[0].valid = sq_ff.valid;
      root_src[0].pay = sq_ff.pay;
      root_src[0].zero = (m2 == 64'd0);
      root_src[0].vx = sq_ff.vx;
      root_src[0].vy = sq_ff.vy;
      root_src[0].vz = sq_ff.vz;
      root_src[0].n = m2;
      root_src[0].r = 64'd0;
      for (int k = 1; k < gws_pkg::SqrtSteps; k++) begin
         root_src[k] = root_ff[k-1];
      end
      for (int k = 0; k < gws_pkg::SqrtSteps; k++) begin
         root_in[k] = root_step(root_src[k], k);
      end
   end

   always_comb begin
      root_type last;
      logic [31:0] len;
      last = root_ff[gws_pkg::SqrtSteps-1];
      len = last.r[31:0];
      div_src[0].valid = last.valid;
      div_src[0].pay = last.pay;
      div_src[0].zero = last.zero;
      div_src[0].len = len;
      div_src[0].neg = {last.vz[31], last.vy[31], last.vx[31]};
      div_src[0].rem[0] = (48'(mag32(last.vx)) << 14) + 48'(len >> 1);
      div_src[0].rem[1] = (48'(mag32(last.vy)) << 14) + 48'(len >> 1);
      div_src[0].rem[2] = (48'(mag32(last.vz)) << 14) + 48'(len >> 1);
      div_src[0].q = '0;
      div_in[0] = div_src[0];
      for (int k = 1; k <= gws_pkg::DivBits; k++) begin
         div_src[k] = div_ff[k-1];
      end
      for (int k = 1; k <= gws_pkg::DivBits; k++) begin
         div_in[k] = div_src[k];
         for (int c = 0; c < 3; c++) begin
            if (div_src[k].rem[c] >= (48'(div_src[k].len) << (gws_pkg::DivBits - k))) begin
               div_in[k].rem[c] = div_src[k].rem[c]
                                  - (48'(div_src[k].len) << (gws_pkg::DivBits - k));
               div_in[k].q[c][gws_pkg::DivBits - k] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      div_type d;
      d = div_ff[gws_pkg::DivBits];
      res_in.valid = d.valid;
      res_in.pay = d.pay;
      if (d.zero) begin
         res_in.norm_x = 16'sd0;
         res_in.norm_y = 16'(gws_pkg::NormOne);
         res_in.norm_z = 16'sd0;
      end else begin
         res_in.norm_x = finish(d.q[0], d.neg[0]);
         res_in.norm_y = finish(d.q[1], d.neg[1]);
         res_in.norm_z = finish(d.q[2], d.neg[2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vec_ff.valid <= 1'b0;
         sq_ff.valid <= 1'b0;
         for (int k = 0; k < gws_pkg::SqrtSteps; k++) begin
            root_ff[k].valid <= 1'b0;
         end
         for (int k = 0; k <= gws_pkg::DivBits; k++) begin
            div_ff[k].valid <= 1'b0;
         end
         res_ff.valid <= 1'b0;
      end else if (adv) begin
         vec_ff <= vec_in;
         sq_ff <= sq_in;
         for (int k = 0; k < gws_pkg::SqrtSteps; k++) begin
            root_ff[k] <= root_in[k];
         end
         for (int k = 0; k <= gws_pkg::DivBits; k++) begin
            div_ff[k] <= div_in[k];
         end
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

[design/gerstner_wave_sum.sv]
// Gerstner wave sum: the top level with the wave-serial front end and the result register.
// Depends on gws_pkg, gws_sincos (sine and cosine units) and gws_norm (output stage).
//
// One surface point is accepted per pass over the wave set (eight waves in the shipped
// set), and the next point can be taken while the last wave of the current one is issued:
// the front end holds the point and issues one wave per cycle, while the pipeline is not
// frozen, into an eleven-stage phase, sine/cosine and multiply pipeline that accumulates
// the wave terms. The summed point then goes through a 32-stage square root and a
// 16-stage division for the normal. rsp_stall while a result is held freezes the pipeline.
// The sea_level register is written through the csr port, which is always ready.
module gerstner_wave_sum (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_z,
   input  logic [31:0]        req_time_now,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_disp_x,
   output logic signed [31:0] rsp_disp_y,
   output logic signed [31:0] rsp_disp_z,
   output logic signed [31:0] rsp_height,
   output logic signed [15:0] rsp_norm_x,
   output logic signed [15:0] rsp_norm_y,
   output logic signed [15:0] rsp_norm_z,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic signed [31:0] csr_data
);

   typedef struct packed {
      logic                         valid;
      logic                         first;
      logic                         last;
      logic [gws_pkg::WaveBits-1:0] wave;
      logic signed [31:0]           px;
      logic signed [31:0]           pz;
   } tag_type;

   localparam gws_pkg::coeff_tab_type Coeffs = gws_pkg::build_coeffs();
   localparam logic [gws_pkg::WaveBits-1:0] LastWave = gws_pkg::WaveBits'(gws_pkg::NumWaves - 1);
   localparam logic signed [gws_pkg::AccBits-1:0] NyInit =
      gws_pkg::AccBits'(64'h1_0000_0000);

   logic                         adv;
   logic                         take;
   logic                         issue_last;
   logic                         busy_ff;
   logic [gws_pkg::WaveBits-1:0] wave_ff;
   logic signed [31:0]           px_ff;
   logic signed [31:0]           pz_ff;
   logic [31:0]                  t_ff;
   logic signed [31:0]           sea_ff;
   gws_pkg::coeff_type           cf_issue;
   gws_pkg::coeff_type           cf_term;
   tag_type                      tag1_in;
   tag_type                      tag1_ff;
   tag_type                      tag2_ff;
   tag_type                      tagd_ff [gws_pkg::SinLat];
   tag_type                      tag9_ff;
   logic [47:0]                  mx_ff;
   logic [47:0]                  mz_ff;
   logic [47:0]                  mt_ff;
   logic [47:0]                  phsum;
   logic [31:0]                  ph_ff;
   logic signed [31:0]           sine;
   logic signed [31:0]           cosine;
   logic signed [31:0]           tx_ff;
   logic signed [31:0]           ty_ff;
   logic signed [31:0]           tz_ff;
   logic signed [31:0]           tnx_ff;
   logic signed [31:0]           tny_ff;
   logic signed [31:0]           tnz_ff;
   gws_pkg::sum_type             sum_ff;
   gws_pkg::sum_type             sum_in;
   gws_pkg::res_type             res;
   gws_pkg::res_type             out_ff;

   function automatic logic signed [gws_pkg::AccBits-1:0] ext(logic signed [31:0] v);
      return {{(gws_pkg::AccBits - 32){v[31]}}, v};
   endfunction

   assign adv = !out_ff.valid || !rsp_stall;
   assign issue_last = (wave_ff == LastWave);
   assign req_stall = !(adv && (!busy_ff || issue_last));
   assign take = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sea_ff <= 32'sd0;
      end else if (csr_valid) begin
         sea_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         wave_ff <= '0;
      end else if (adv) begin
         if (take) begin
            busy_ff <= 1'b1;
            wave_ff <= '0;
         end else if (busy_ff && issue_last) begin
            busy_ff <= 1'b0;
         end else if (busy_ff) begin
            wave_ff <= wave_ff + gws_pkg::WaveBits'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         px_ff <= req_pos_x;
         pz_ff <= req_pos_z;
         t_ff <= req_time_now;
      end
   end

   always_comb begin
      cf_issue = Coeffs[wave_ff];
      tag1_in.valid = busy_ff;
      tag1_in.first = (wave_ff == '0);
      tag1_in.last = issue_last;
      tag1_in.wave = wave_ff;
      tag1_in.px = px_ff;
      tag1_in.pz = pz_ff;
      phsum = mx_ff + mz_ff - mt_ff;
      cf_term = Coeffs[tagd_ff[gws_pkg::SinLat-1].wave];
   end

   gws_sincos u_sin (
      .clock (clock),
      .adv   (adv),
      .phase (ph_ff),
      .sine  (sine)
   );

   gws_sincos u_cos (
      .clock (clock),
      .adv   (adv),
      .phase (ph_ff + 32'h4000_0000),
      .sine  (cosine)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         mx_ff <= 48'(px_ff * cf_issue.fx);
         mz_ff <= 48'(pz_ff * cf_issue.fz);
         mt_ff <= 48'(64'(t_ff) * 64'(cf_issue.ft));
         ph_ff <= phsum[47:16];
         tx_ff <= gws_pkg::mul_q30(cf_term.cx, cosine);
         ty_ff <= gws_pkg::mul_q30(cf_term.amp, sine);
         tz_ff <= gws_pkg::mul_q30(cf_term.cz, cosine);
         tnx_ff <= gws_pkg::mul_q30(cf_term.kx, cosine);
         tny_ff <= gws_pkg::mul_q30(cf_term.qka, sine);
         tnz_ff <= gws_pkg::mul_q30(cf_term.kz, cosine);
      end
   end

   always_comb begin
      sum_in = sum_ff;
      sum_in.valid = tag9_ff.valid && tag9_ff.last;
      if (tag9_ff.valid) begin
         sum_in.px = tag9_ff.px;
         sum_in.pz = tag9_ff.pz;
         if (tag9_ff.first) begin
            sum_in.sx = ext(tx_ff);
            sum_in.sy = ext(ty_ff);
            sum_in.sz = ext(tz_ff);
            sum_in.nx = -ext(tnx_ff);
            sum_in.ny = NyInit - ext(tny_ff);
            sum_in.nz = -ext(tnz_ff);
         end else begin
            sum_in.sx = sum_ff.sx + ext(tx_ff);
            sum_in.sy = sum_ff.sy + ext(ty_ff);
            sum_in.sz = sum_ff.sz + ext(tz_ff);
            sum_in.nx = sum_ff.nx - ext(tnx_ff);
            sum_in.ny = sum_ff.ny - ext(tny_ff);
            sum_in.nz = sum_ff.nz - ext(tnz_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
         for (int k = 0; k < gws_pkg::SinLat; k++) begin
            tagd_ff[k].valid <= 1'b0;
         end
         tag9_ff.valid <= 1'b0;
         sum_ff.valid <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (adv) begin
         tag1_ff <= tag1_in;
         tag2_ff <= tag1_ff;
         tagd_ff[0] <= tag2_ff;
         for (int k = 1; k < gws_pkg::SinLat; k++) begin
            tagd_ff[k] <= tagd_ff[k-1];
         end
         tag9_ff <= tagd_ff[gws_pkg::SinLat-1];
         sum_ff <= sum_in;
         out_ff <= res;
      end
   end

   gws_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .sea_level (sea_ff),
      .sum       (sum_ff),
      .res       (res)
   );

   assign rsp_valid = out_ff.valid;
   assign rsp_disp_x = out_ff.pay.disp_x;
   assign rsp_disp_y = out_ff.pay.disp_y;
   assign rsp_disp_z = out_ff.pay.disp_z;
   assign rsp_height = out_ff.pay.height;
   assign rsp_norm_x = out_ff.norm_x;
   assign rsp_norm_y = out_ff.norm_y;
   assign rsp_norm_z = out_ff.norm_z;

`ifndef SYNTHESIS
   a_take_starts_wave0: assert property (@(posedge clock) disable iff (reset)
      take |=> busy_ff && wave_ff == '0)
      else $error("accepted beat did not start at the first wave");

   a_frozen_front: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(wave_ff) && $stable(busy_ff))
      else $error("front end moved while the pipeline was frozen");

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_norm_y <= 16'sd16384 && rsp_norm_y >= -16'sd16384
                    && rsp_norm_x <= 16'sd16384 && rsp_norm_x >= -16'sd16384)
      else $error("normal component out of range");

   a_sum_after_last: assert property (@(posedge clock) disable iff (reset)
      adv && tag9_ff.valid && tag9_ff.last |=> sum_ff.valid)
      else $error("last wave did not produce a summed beat");
`endif

endmodule
